// ===== rtl/ptb_pkg.sv =====
package ptb_pkg;

  localparam int NumTimers   = 32;
  localparam int IdxW        = $clog2(NumTimers);
  localparam int CntW        = 15;
  localparam int MaxCatchup  = 10;
  localparam int TickW       = $clog2(MaxCatchup + 1);
  localparam logic [CntW-1:0] PresetReset = 15'h7fff;

  localparam int Div100ms = 5;
  localparam int DivTimer = 10;
  localparam int Div1s    = 50;
  localparam int Div1min  = 3000;
  localparam int R100msW  = $clog2(Div100ms);
  localparam int RTimerW  = $clog2(DivTimer);
  localparam int R1sW     = $clog2(Div1s);
  localparam int R1minW   = $clog2(Div1min);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_SCAN  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_TCHK = 4'd1,
    S_TICK = 4'd2,
    S_SRD  = 4'd3,
    S_SINC = 4'd4,
    S_WRD  = 4'd5,
    S_WWR  = 4'd6,
    S_SCLR = 4'd7,
    S_CRD  = 4'd8,
    S_CCMP = 4'd9,
    S_FRD  = 4'd10,
    S_FOUT = 4'd11
  } step_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_DISPATCH,
    A_TICK,
    A_RD_SWEEP,
    A_RD_REQ,
    A_WR_INC,
    A_WR_REQ,
    A_CLR_DONE,
    A_SET_DONE,
    A_OUT
  } act_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_TICKS_ZERO,
    C_SWEEP,
    C_LAST,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic ticks_zero;
    logic sweep;
    logic last;
    logic out_busy;
  } stat_t;

  function automatic cw_t step_rom(step_e s);
    cw_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE};
    unique case (s)
      S_IDLE: w = '{act: A_DISPATCH, cond: C_DISPATCH,   tgt_t: S_IDLE, tgt_f: S_IDLE};
      S_TCHK: w = '{act: A_NONE,     cond: C_TICKS_ZERO, tgt_t: S_FRD,  tgt_f: S_TICK};
      S_TICK: w = '{act: A_TICK,     cond: C_SWEEP,      tgt_t: S_SRD,  tgt_f: S_TCHK};
      S_SRD:  w = '{act: A_RD_SWEEP, cond: C_ALWAYS,     tgt_t: S_SINC, tgt_f: S_SINC};
      S_SINC: w = '{act: A_WR_INC,   cond: C_LAST,       tgt_t: S_TCHK, tgt_f: S_SRD};
      S_WRD:  w = '{act: A_RD_REQ,   cond: C_ALWAYS,     tgt_t: S_WWR,  tgt_f: S_WWR};
      S_WWR:  w = '{act: A_WR_REQ,   cond: C_ALWAYS,     tgt_t: S_FRD,  tgt_f: S_FRD};
      S_SCLR: w = '{act: A_CLR_DONE, cond: C_ALWAYS,     tgt_t: S_CRD,  tgt_f: S_CRD};
      S_CRD:  w = '{act: A_RD_SWEEP, cond: C_ALWAYS,     tgt_t: S_CCMP, tgt_f: S_CCMP};
      S_CCMP: w = '{act: A_SET_DONE, cond: C_LAST,       tgt_t: S_FRD,  tgt_f: S_CRD};
      S_FRD:  w = '{act: A_RD_REQ,   cond: C_ALWAYS,     tgt_t: S_FOUT, tgt_f: S_FOUT};
      S_FOUT: w = '{act: A_OUT,      cond: C_OUT_BUSY,   tgt_t: S_FOUT, tgt_f: S_IDLE};
      default: w = '{act: A_NONE,    cond: C_ALWAYS,     tgt_t: S_IDLE, tgt_f: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_e dispatch(logic [1:0] req);
    step_e s;
    unique case (req)
      REQ_TICK:  s = S_TCHK;
      REQ_WRITE: s = S_WRD;
      REQ_SCAN:  s = S_SCLR;
      default:   s = S_FRD;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ptb_seq.sv =====
module ptb_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptb_pkg::stat_t  stat_i,
  input  logic [1:0]      req_type_i,
  output ptb_pkg::cw_t    cw_o
);

  ptb_pkg::step_e pc_q, pc_d;
  ptb_pkg::cw_t   cw;
  logic           take;

  always_comb begin
    cw = ptb_pkg::step_rom(pc_q);
  end

  always_comb begin
    unique case (cw.cond)
      ptb_pkg::C_ALWAYS:     take = 1'b1;
      ptb_pkg::C_DISPATCH:   take = 1'b0;
      ptb_pkg::C_TICKS_ZERO: take = stat_i.ticks_zero;
      ptb_pkg::C_SWEEP:      take = stat_i.sweep;
      ptb_pkg::C_LAST:       take = stat_i.last;
      ptb_pkg::C_OUT_BUSY:   take = stat_i.out_busy;
      default:               take = 1'b1;
    endcase
    if (cw.cond == ptb_pkg::C_DISPATCH) begin
      pc_d = stat_i.in_valid ? ptb_pkg::dispatch(req_type_i) : ptb_pkg::S_IDLE;
    end else begin
      pc_d = take ? cw.tgt_t : cw.tgt_f;
    end
  end

  always_comb begin
    cw_o = cw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ptb_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/plc_timer_bank_with_clock_pulses_core.sv =====
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_ready_o   req_type_i .. clear_count_i
// out      out  out_valid_o/out_ready_i pulse_*_o, done_vector_o, count_value_o
//
// One request at a time, stepped by a microcode sequencer; one timer-memory
// access per cycle. A tick sweeps the 32 timers on every 10th tick, a write
// updates its entry, a scan compares all 32, and each ends by reading its
// entry. The next request is taken in the cycle after the result loads.
// Reset clears control state and the per-entry valid bits of the timer memory.
// A result waits in the output register; a stalled output holds the last step.
module plc_timer_bank_with_clock_pulses_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [9:0]                    elapsed_ticks_i,
  input  logic [ptb_pkg::IdxW-1:0]      timer_index_i,
  input  logic                          enable_bit_i,
  input  logic                          write_preset_i,
  input  logic [ptb_pkg::CntW-1:0]      preset_value_i,
  input  logic                          clear_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pulse_cs_o,
  output logic                          pulse_ds_o,
  output logic                          pulse_1s_o,
  output logic                          pulse_1min_o,
  output logic [31:0]                   done_vector_o,
  output logic [ptb_pkg::CntW-1:0]      count_value_o
);

  localparam int CntW = ptb_pkg::CntW;
  localparam int IdxW = ptb_pkg::IdxW;
  localparam int NT   = ptb_pkg::NumTimers;

  ptb_pkg::cw_t   cw;
  ptb_pkg::stat_t stat;

  logic [IdxW-1:0]              idx_q, sidx_q, sidx_d;
  logic                         en_bit_q, wp_q, clr_q;
  logic [CntW-1:0]              pv_q;
  logic [ptb_pkg::TickW-1:0]    ticks_q, ticks_d;
  logic [ptb_pkg::R100msW-1:0]  r5_q, r5_d;
  logic [ptb_pkg::RTimerW-1:0]  r10_q, r10_d;
  logic [ptb_pkg::R1sW-1:0]     r50_q, r50_d;
  logic [ptb_pkg::R1minW-1:0]   r3k_q, r3k_d;
  logic [3:0]                   pulse_q, pulse_d;
  logic [NT-1:0]                en_q;
  logic [NT-1:0]                done_q;

  logic [2*CntW-1:0]            mem [NT];
  logic [NT-1:0]                vld_q;
  logic [2*CntW-1:0]            rd_q;
  logic                         rd_vld_q;
  logic [CntW-1:0]              rd_cnt, rd_pre, wr_cnt, wr_pre;
  logic                         mem_rd, mem_wr;
  logic [IdxW-1:0]              rd_addr, wr_addr;

  logic                         out_valid_q;
  logic [3:0]                   out_pulse_q;
  logic [31:0]                  out_done_q;
  logic [CntW-1:0]              out_cnt_q;
  logic                         accept, out_load;

  ptb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .req_type_i (req_type_i),
    .cw_o       (cw)
  );

  assign in_ready_o = (cw.act == ptb_pkg::A_DISPATCH);
  assign accept     = in_valid_i && in_ready_o;

  assign stat.in_valid   = in_valid_i;
  assign stat.ticks_zero = (ticks_q == '0);
  assign stat.sweep      = (r10_q == ptb_pkg::RTimerW'(ptb_pkg::DivTimer - 1));
  assign stat.last       = (sidx_q == IdxW'(NT - 1));
  assign stat.out_busy   = out_valid_q && !out_ready_i;

  assign out_load = (cw.act == ptb_pkg::A_OUT) && !stat.out_busy;

  assign rd_cnt = rd_vld_q ? rd_q[CntW-1:0] : '0;
  assign rd_pre = rd_vld_q ? rd_q[2*CntW-1:CntW] : ptb_pkg::PresetReset;

  always_comb begin
    mem_rd  = (cw.act == ptb_pkg::A_RD_SWEEP) || (cw.act == ptb_pkg::A_RD_REQ);
    mem_wr  = (cw.act == ptb_pkg::A_WR_INC) || (cw.act == ptb_pkg::A_WR_REQ);
    rd_addr = (cw.act == ptb_pkg::A_RD_SWEEP) ? sidx_q : idx_q;
    wr_addr = (cw.act == ptb_pkg::A_WR_INC) ? sidx_q : idx_q;
    wr_pre  = rd_pre;
    wr_cnt  = rd_cnt;
    if (cw.act == ptb_pkg::A_WR_INC) begin
      if (en_q[sidx_q] && (rd_cnt < rd_pre)) begin
        wr_cnt = rd_cnt + 1'b1;
      end
    end else begin
      if (wp_q) begin
        wr_pre = pv_q;
      end
      if (clr_q) begin
        wr_cnt = '0;
      end
    end
  end

  always_comb begin
    r5_d    = r5_q;
    r10_d   = r10_q;
    r50_d   = r50_q;
    r3k_d   = r3k_q;
    pulse_d = pulse_q;
    ticks_d = ticks_q;
    sidx_d  = sidx_q;
    case (cw.act)
      ptb_pkg::A_DISPATCH: begin
        ticks_d = (elapsed_ticks_i > 10'(ptb_pkg::MaxCatchup))
                  ? ptb_pkg::TickW'(ptb_pkg::MaxCatchup)
                  : elapsed_ticks_i[ptb_pkg::TickW-1:0];
      end
      ptb_pkg::A_TICK: begin
        ticks_d = ticks_q - 1'b1;
        sidx_d  = '0;
        r5_d  = (r5_q == ptb_pkg::R100msW'(ptb_pkg::Div100ms - 1)) ? '0 : r5_q + 1'b1;
        r10_d = (r10_q == ptb_pkg::RTimerW'(ptb_pkg::DivTimer - 1)) ? '0 : r10_q + 1'b1;
        r50_d = (r50_q == ptb_pkg::R1sW'(ptb_pkg::Div1s - 1)) ? '0 : r50_q + 1'b1;
        r3k_d = (r3k_q == ptb_pkg::R1minW'(ptb_pkg::Div1min - 1)) ? '0 : r3k_q + 1'b1;
        pulse_d[0] = ~pulse_q[0];
        pulse_d[1] = pulse_q[1] ^ (r5_d == '0);
        pulse_d[2] = pulse_q[2] ^ (r50_d == '0);
        pulse_d[3] = pulse_q[3] ^ (r3k_d == '0);
      end
      ptb_pkg::A_CLR_DONE: sidx_d = '0;
      ptb_pkg::A_WR_INC,
      ptb_pkg::A_SET_DONE: sidx_d = sidx_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      sidx_q      <= '0;
      r5_q        <= '0;
      r10_q       <= '0;
      r50_q       <= '0;
      r3k_q       <= '0;
      pulse_q     <= '0;
      en_q        <= '0;
      done_q      <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ticks_q <= ticks_d;
      sidx_q  <= sidx_d;
      r5_q    <= r5_d;
      r10_q   <= r10_d;
      r50_q   <= r50_d;
      r3k_q   <= r3k_d;
      pulse_q <= pulse_d;
      if (cw.act == ptb_pkg::A_WR_REQ) begin
        en_q[idx_q] <= en_bit_q;
      end
      if (cw.act == ptb_pkg::A_CLR_DONE) begin
        done_q <= '0;
      end else if (cw.act == ptb_pkg::A_SET_DONE) begin
        done_q[sidx_q] <= (rd_cnt >= rd_pre);
      end
      if (mem_wr) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (mem_rd) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem[wr_addr] <= {wr_pre, wr_cnt};
    end
    if (mem_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q    <= timer_index_i;
      en_bit_q <= enable_bit_i;
      wp_q     <= write_preset_i;
      pv_q     <= preset_value_i;
      clr_q    <= clear_count_i;
    end
    if (out_load) begin
      out_pulse_q <= pulse_q;
      out_done_q  <= done_q;
      out_cnt_q   <= rd_cnt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_cs_o    = out_pulse_q[0];
  assign pulse_ds_o    = out_pulse_q[1];
  assign pulse_1s_o    = out_pulse_q[2];
  assign pulse_1min_o  = out_pulse_q[3];
  assign done_vector_o = out_done_q;
  assign count_value_o = out_cnt_q;

  a_ticks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q <= ptb_pkg::TickW'(ptb_pkg::MaxCatchup))
    else $error("catch-up tick count out of range");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r5_q < ptb_pkg::R100msW'(ptb_pkg::Div100ms)) &&
    (r3k_q < ptb_pkg::R1minW'(ptb_pkg::Div1min)))
    else $error("tick residue out of range");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_pulse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.act != ptb_pkg::A_TICK) |=> $stable(pulse_q))
    else $error("pulse bits changed outside a tick step");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !(cw.act == ptb_pkg::A_DISPATCH &&
                                        $past(cw.act) == ptb_pkg::A_OUT))
    else $error("result overwritten while output stalled");

endmodule

// ===== dv/timer_bank_checker.sv =====
module timer_bank_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               req_type_i,
  input  logic [9:0]               elapsed_ticks_i,
  input  logic [ptb_pkg::IdxW-1:0] timer_index_i,
  input  logic                     enable_bit_i,
  input  logic                     write_preset_i,
  input  logic [ptb_pkg::CntW-1:0] preset_value_i,
  input  logic                     clear_count_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     pulse_cs_i,
  input  logic                     pulse_ds_i,
  input  logic                     pulse_1s_i,
  input  logic                     pulse_1min_i,
  input  logic [31:0]              done_vector_i,
  input  logic [ptb_pkg::CntW-1:0] count_value_i,
  output int                       mismatch_cnt_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TickWrap = 60000;

  typedef struct packed {
    logic [3:0]               pulses;
    logic [31:0]              done;
    logic [ptb_pkg::CntW-1:0] count;
  } timer_result_t;

  int unsigned                   tick_cnt;
  logic [3:0]                    pulses;
  logic [ptb_pkg::CntW-1:0]      counts [ptb_pkg::NumTimers];
  logic [ptb_pkg::CntW-1:0]      presets[ptb_pkg::NumTimers];
  logic [ptb_pkg::NumTimers-1:0] enables;
  logic [ptb_pkg::NumTimers-1:0] done_flags;

  timer_result_t expected_results[$];
  timer_result_t want;
  timer_result_t got;
  int            mismatch_cnt = 0;
  int            pending_cnt  = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = pending_cnt;

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void clear_bank();
    tick_cnt   = 0;
    pulses     = '0;
    enables    = '0;
    done_flags = '0;
    for (int t = 0; t < ptb_pkg::NumTimers; t++) begin
      counts[t]  = '0;
      presets[t] = ptb_pkg::PresetReset;
    end
  endfunction

  function automatic void run_tick();
    tick_cnt++;
    pulses[0] = ~pulses[0];
    if (tick_cnt % ptb_pkg::Div100ms == 0) pulses[1] = ~pulses[1];
    if (tick_cnt % ptb_pkg::DivTimer == 0) begin
      for (int t = 0; t < ptb_pkg::NumTimers; t++) begin
        if (enables[t] && counts[t] < presets[t]) counts[t] = counts[t] + 1'b1;
      end
    end
    if (tick_cnt % ptb_pkg::Div1s == 0) pulses[2] = ~pulses[2];
    if (tick_cnt % ptb_pkg::Div1min == 0) pulses[3] = ~pulses[3];
    if (tick_cnt >= TickWrap) tick_cnt = 0;
  endfunction

  function automatic timer_result_t apply_request(
    logic [1:0] req, logic [9:0] ticks, logic [ptb_pkg::IdxW-1:0] idx,
    logic en, logic wp, logic [ptb_pkg::CntW-1:0] pv, logic clr);
    timer_result_t r;
    int            n;
    n = (ticks > ptb_pkg::MaxCatchup) ? ptb_pkg::MaxCatchup : int'(ticks);
    case (req)
      ptb_pkg::REQ_TICK: begin
        for (int k = 0; k < n; k++) run_tick();
      end
      ptb_pkg::REQ_WRITE: begin
        enables[idx] = en;
        if (wp) presets[idx] = pv;
        if (clr) counts[idx] = '0;
      end
      ptb_pkg::REQ_SCAN: begin
        for (int t = 0; t < ptb_pkg::NumTimers; t++) begin
          done_flags[t] = counts[t] >= presets[t];
        end
      end
      default: ;
    endcase
    r.pulses = pulses;
    r.done   = 32'(done_flags);
    r.count  = counts[idx];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bank();
      expected_results.delete();
      pending_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          got  = '{pulses: {pulse_1min_i, pulse_1s_i, pulse_ds_i, pulse_cs_i},
                   done: done_vector_i, count: count_value_i};
          if (got.pulses[0] !== want.pulses[0])
            report_mismatch($sformatf("pulse_cs got %b exp %b",
                                      got.pulses[0], want.pulses[0]));
          if (got.pulses[1] !== want.pulses[1])
            report_mismatch($sformatf("pulse_ds got %b exp %b",
                                      got.pulses[1], want.pulses[1]));
          if (got.pulses[2] !== want.pulses[2])
            report_mismatch($sformatf("pulse_1s got %b exp %b",
                                      got.pulses[2], want.pulses[2]));
          if (got.pulses[3] !== want.pulses[3])
            report_mismatch($sformatf("pulse_1min got %b exp %b",
                                      got.pulses[3], want.pulses[3]));
          if (got.done !== want.done)
            report_mismatch($sformatf("done_vector got %h exp %h", got.done, want.done));
          if (got.count !== want.count)
            report_mismatch($sformatf("count_value got %0d exp %0d", got.count, want.count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_request(req_type_i, elapsed_ticks_i, timer_index_i,
                                                 enable_bit_i, write_preset_i,
                                                 preset_value_i, clear_count_i));
      end
      pending_cnt = expected_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqUnused = 2'd3;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               req_type_i      = '0;
  logic [9:0]               elapsed_ticks_i = '0;
  logic [ptb_pkg::IdxW-1:0] timer_index_i   = '0;
  logic                     enable_bit_i    = 1'b0;
  logic                     write_preset_i  = 1'b0;
  logic [ptb_pkg::CntW-1:0] preset_value_i  = '0;
  logic                     clear_count_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic                     pulse_cs_o;
  logic                     pulse_ds_o;
  logic                     pulse_1s_o;
  logic                     pulse_1min_o;
  logic [31:0]              done_vector_o;
  logic [ptb_pkg::CntW-1:0] count_value_o;

  int mismatches;
  int pending;
  int src_idle  = 0;
  int snk_stall = 0;

  always #5ns clk_i = ~clk_i;

  plc_timer_bank_with_clock_pulses_core dut (.*);

  timer_bank_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .elapsed_ticks_i(elapsed_ticks_i),
    .timer_index_i  (timer_index_i),
    .enable_bit_i   (enable_bit_i),
    .write_preset_i (write_preset_i),
    .preset_value_i (preset_value_i),
    .clear_count_i  (clear_count_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pulse_cs_i     (pulse_cs_o),
    .pulse_ds_i     (pulse_ds_o),
    .pulse_1s_i     (pulse_1s_o),
    .pulse_1min_i   (pulse_1min_o),
    .done_vector_i  (done_vector_o),
    .count_value_i  (count_value_o),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= snk_stall);
  end

  task automatic send_req(logic [1:0] req, logic [9:0] ticks,
                          logic [ptb_pkg::IdxW-1:0] idx, logic en, logic wp,
                          logic [ptb_pkg::CntW-1:0] pv, logic clr);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    elapsed_ticks_i <= ticks;
    timer_index_i   <= idx;
    enable_bit_i    <= en;
    write_preset_i  <= wp;
    preset_value_i  <= pv;
    clear_count_i   <= clr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random();
    logic [1:0]               req;
    logic [9:0]               ticks;
    logic [ptb_pkg::CntW-1:0] pv;
    logic                     clr;
    int                       pick;
    pick  = $urandom_range(99);
    ticks = 10'($urandom_range(1023));
    pv    = ptb_pkg::CntW'($urandom_range(32767));
    clr   = 1'($urandom_range(1));
    if (pick < 62) begin
      req   = ptb_pkg::REQ_TICK;
      ticks = ($urandom_range(99) < 85) ? 10'($urandom_range(1023, 10))
                                        : 10'($urandom_range(9));
    end else if (pick < 90) begin
      req = ptb_pkg::REQ_WRITE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: pv = ptb_pkg::CntW'($urandom_range(40));
        7:       pv = ptb_pkg::PresetReset;
        default: ;
      endcase
      clr = ($urandom_range(99) < 30);
    end else if (pick < 97) begin
      req = ptb_pkg::REQ_SCAN;
    end else begin
      req = ReqUnused;
    end
    send_req(req, ticks, ptb_pkg::IdxW'($urandom_range(ptb_pkg::NumTimers - 1)),
             ($urandom_range(99) < 70), ($urandom_range(99) < 60), pv, clr);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle  = 10;
    snk_stall = 49;
    send_req(ptb_pkg::REQ_SCAN,  10'd0,    5'd0,  1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd0,    5'd3,  1'b1, 1'b1, 15'h7fff,  1'b1);
    send_req(ptb_pkg::REQ_TICK,  10'd1,    5'd0,  1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd1023, 5'd31, 1'b1, 1'b1, 15'h7fff,  1'b1);
    send_req(ptb_pkg::REQ_TICK,  10'd11,   5'd1,  1'b0, 1'b0, 15'd0,     1'b0);
    // zero preset: done at once
    send_req(ptb_pkg::REQ_WRITE, 10'd1023, 5'd0,  1'b1, 1'b1, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_SCAN,  10'd0,    5'd0,  1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_WRITE, 10'd0,    5'd31, 1'b1, 1'b1, 15'd2,     1'b1);
    send_req(ptb_pkg::REQ_WRITE, 10'd0,    5'd5,  1'b1, 1'b1, 15'h7fff,  1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd10,   5'd31, 1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd10,   5'd5,  1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd10,   5'd31, 1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd10,   5'd31, 1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_SCAN,  10'd1023, 5'd31, 1'b1, 1'b1, 15'h7fff,  1'b1);
    send_req(ptb_pkg::REQ_WRITE, 10'd0,    5'd31, 1'b0, 1'b0, 15'd0,     1'b1);
    send_req(ReqUnused,          10'd1023, 5'd31, 1'b1, 1'b1, 15'h7fff,  1'b1);
    send_req(ptb_pkg::REQ_WRITE, 10'd0,    5'd5,  1'b1, 1'b0, 15'd1,     1'b0);
    send_req(ptb_pkg::REQ_TICK,  10'd5,    5'd5,  1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_SCAN,  10'd0,    5'd31, 1'b0, 1'b0, 15'd0,     1'b0);
    send_req(ptb_pkg::REQ_SCAN,  10'd0,    5'd5,  1'b0, 1'b0, 15'd0,     1'b0);

    for (int i = 0; i < 180; i++) send_random();
    src_idle  = 49;
    snk_stall = 10;
    for (int i = 0; i < 180; i++) send_random();
    src_idle  = 0;
    snk_stall = 0;
    for (int i = 0; i < 180; i++) send_random();
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== plc_timer_bank_with_clock_pulses_core.f =====
rtl/ptb_pkg.sv
rtl/ptb_seq.sv
rtl/plc_timer_bank_with_clock_pulses_core.sv
dv/timer_bank_checker.sv
dv/tb.sv
